FILE: rtl/rccd_pkg.sv
// Package with shared types, constants and helper functions for the command decoder.
`default_nettype none
package rccd_pkg;

  localparam int MaxLineDefault = 512;
  localparam int ChannelsDefault = 8;

  localparam logic [9:0] SpeedMax = 10'd990;
  localparam logic [9:0] SpeedMin = 10'd600;
  localparam logic [9:0] SpeedStep = 10'd200;
  localparam logic [11:0] PulseMax = 12'd2500;
  localparam logic [11:0] PulseCentre = 12'd1500;
  localparam logic [11:0] PulseLeft = 12'd1100;
  localparam logic [11:0] PulseRight = 12'd1900;
  localparam logic [10:0] TimeLimit = 11'd100;

  localparam logic [1:0] CfgSpeedReset = 2'd0;
  localparam logic [1:0] CfgClearDist = 2'd1;
  localparam logic [1:0] CfgStopDist = 2'd2;
  localparam logic [1:0] CfgDeadZone = 2'd3;

  typedef enum logic [3:0] {
    T_NONE, T_BACK, T_LEFT, T_RIGHT, T_STOP, T_ANG1, T_ANG2, T_ANG3,
    T_ANG4, T_ANG5, T_ANG6, T_ADD, T_SLOW, T_HORN, T_NOHORN, T_JOY
  } token_t;

  // Summary of one finished message, handed from the parser to the executor.
  typedef struct packed {
    token_t      code;
    logic        fwd;
    logic [9:0]  range_cm;
    logic        ang_neg;
    logic [11:0] angle;
    logic        joy_ready;
    logic        joy_xneg;
    logic        joy_yneg;
    logic [7:0]  joy_x;
    logic [7:0]  joy_y;
    logic        pending;
    logic [2:0]  pend_chan;
    logic [11:0] pend_pulse;
  } msg_t;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Decimal accumulate with saturation; narrow widths keep this small.
  function automatic logic [12:0] acc(input logic [12:0] v, input logic [7:0] c,
                                      input logic [12:0] lim);
    logic [16:0] t;
    if (!is_dig(c)) return v;
    t = {4'd0, v} * 17'd10 + {13'd0, c[3:0]};
    return (t > {4'd0, lim}) ? lim : t[12:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rccd_parse.sv
// Front part: byte-by-byte parsing of a message, classification at message end.
`default_nettype none
module rccd_parse
  import rccd_pkg::*;
#(
  parameter int MAX_LINE = MaxLineDefault,
  parameter int CHANNELS = ChannelsDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] rx_byte,
  input  wire logic [9:0] range_cm,
  input  wire logic       end_of_message,
  output msg_t            msg,
  output logic            msg_valid
);

  localparam int PW = $clog2(MAX_LINE + 1);
  localparam int CW = $clog2(CHANNELS);

  logic [7:0]  pfx [6];
  logic [PW-1:0] pos;
  logic        f_num, f_pulse, f_time, f_prevt, f_send, f_tend, f_jend, f_aend;
  logic [7:0]  chan_acc;
  logic [11:0] pulse_acc;
  logic [10:0] time_acc;
  logic [11:0] ang_acc;
  logic        ang_started, ang_neg;
  logic [7:0]  jx, jy;
  logic [1:0]  jaxis, jneg;
  logic        jready;
  logic [11:0] ptab [CHANNELS];
  logic [CW-1:0] last_ch;
  logic        pend;
  logic [2:0]  pend_ch;
  logic [11:0] pend_pl;

  function automatic logic m4(input logic [7:0] b0, b1, b2, b3, input logic [7:0] p [6]);
    return p[0] == b0 && p[1] == b1 && p[2] == b2 && p[3] == b3;
  endfunction

  // Classify a prefix of the given length.
  function automatic token_t classify(input logic [7:0] p [6], input logic [PW-1:0] n);
    logic l6, l5, l4, l3;
    l6 = n >= PW'(6); l5 = n >= PW'(5); l4 = n >= PW'(4); l3 = n >= PW'(3);
    if (l6 && p[0] == "<" && m4("B","D","N","D",'{p[1],p[2],p[3],p[4],0,0}) && p[5] == ">")
      return T_BACK;
    if (l4 && m4("B","D","N","D",p)) return T_BACK;
    if (l6 && p[0] == "<" && m4("B","L","T","D",'{p[1],p[2],p[3],p[4],0,0}) && p[5] == ">")
      return T_LEFT;
    if (l4 && m4("B","L","T","D",p)) return T_LEFT;
    if (l6 && p[0] == "<" && m4("B","R","T","D",'{p[1],p[2],p[3],p[4],0,0}) && p[5] == ">")
      return T_RIGHT;
    if (l4 && m4("B","R","T","D",p)) return T_RIGHT;
    if (l6 && p[0] == "<" && p[1] == "B" && p[4] == "U" && p[5] == ">" &&
        ((p[2] == "L" && p[3] == "T") || (p[2] == "D" && p[3] == "N") ||
         (p[2] == "U" && p[3] == "P") || (p[2] == "R" && p[3] == "T")))
      return T_STOP;
    if (l4 && (m4("B","S","T","D",p) || m4("B","L","T","U",p) || m4("B","D","N","U",p) ||
               m4("B","U","P","U",p) || m4("B","R","T","U",p)))
      return T_STOP;
    if (l5 && p[0] == "<" && p[1] == "S" && p[4] == "-") begin
      if (p[2] == "U" && p[3] == "P") return T_ANG1;
      if (p[2] == "L" && p[3] == "T") return T_ANG2;
      if (p[2] == "D" && p[3] == "N") return T_ANG3;
      if (p[2] == "R" && p[3] == "T") return T_ANG4;
      if (p[2] == "D" && p[3] == "L") return T_ANG5;
      if (p[2] == "D" && p[3] == "R") return T_ANG6;
    end
    if (l4 && m4("B","U","A","D",p)) return T_ADD;
    if (l4 && m4("B","U","M","D",p)) return T_SLOW;
    if (l4 && m4("B","U","S","D",p)) return T_HORN;
    if (l4 && m4("B","U","S","N",p)) return T_NOHORN;
    if (l3 && p[0] == "<" && p[1] == "Z" && p[2] == "L") return T_JOY;
    return T_NONE;
  endfunction

  // Working copies updated by the current byte.
  logic [7:0]  pfx_n [6];
  logic [PW-1:0] pos_n;
  logic        active;
  token_t      code_n;
  logic        fwd_n;

  always_comb begin
    for (int i = 0; i < 6; i++) pfx_n[i] = pfx[i];
    active = pos < PW'(MAX_LINE);
    pos_n = active ? pos + PW'(1) : pos;
    if (active && pos < PW'(6)) pfx_n[pos[2:0]] = rx_byte;
    code_n = classify(pfx_n, pos_n);
    fwd_n = (pos_n >= PW'(6) && pfx_n[0] == "<" && pfx_n[1] == "B" && pfx_n[2] == "U" &&
             pfx_n[3] == "P" && pfx_n[4] == "D" && pfx_n[5] == ">") ||
            (pos_n >= PW'(4) && m4("B","U","P","D",pfx_n));
  end

  // Per-byte state update, following the processing order of one byte.
  always_ff @(posedge clk) begin
    logic [7:0] c;
    logic tend, was_time, may_write;
    logic [11:0] v;
    logic [10:0] t_new;
    logic [12:0] tmp;
    c = rx_byte;
    msg_valid <= !rst && take && end_of_message;
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) ptab[i] <= PulseCentre;
      last_ch <= '0;
    end
    if (rst || (take && end_of_message)) begin
      for (int i = 0; i < 6; i++) pfx[i] <= '0;
      pos <= '0;
      {f_num, f_pulse, f_time, f_prevt, f_send, f_tend, f_jend, f_aend} <= '0;
      chan_acc <= '0; pulse_acc <= '0; time_acc <= '0; ang_acc <= '0;
      ang_started <= 1'b0; ang_neg <= 1'b0;
      jx <= '0; jy <= '0; jaxis <= '0; jneg <= '0; jready <= 1'b0;
      pend <= 1'b0; pend_ch <= '0; pend_pl <= '0;
    end
    if (!rst && take) begin
      // Local copies so the end-of-message summary sees this byte's effect.
      logic [7:0] ca; logic [11:0] pa; logic [10:0] ta; logic [11:0] aa;
      logic fn, fp, ft, fpt, fs, fa, fj, ast, an, jr, pd;
      logic [7:0] x, y; logic [1:0] ax, ng; logic [CW-1:0] lc; logic [2:0] pc;
      logic [11:0] pp;
      logic [11:0] tab [CHANNELS];
      ca = chan_acc; pa = pulse_acc; ta = time_acc; aa = ang_acc;
      fn = f_num; fp = f_pulse; ft = f_time; fpt = f_prevt; fs = f_send;
      fa = f_aend; fj = f_jend; ast = ang_started; an = ang_neg; jr = jready;
      x = jx; y = jy; ax = jaxis; ng = jneg; lc = last_ch; pd = pend; pc = pend_ch;
      pp = pend_pl;
      for (int i = 0; i < CHANNELS; i++) tab[i] = ptab[i];
      tend = f_tend;
      if (active) begin
        if (c == 8'd0) tend = 1'b1;
        if (!tend) begin
          if (!fs) begin
            if (c == 8'h0A) fs = 1'b1;
            else begin
              was_time = ft;
              may_write = (code_n == T_NONE);
              if (fn) begin
                if (c != "P") begin
                  tmp = acc({5'd0, ca}, c, 13'd255); ca = tmp[7:0];
                end else fn = 1'b0;
              end
              if (fp) begin
                if (c != "T" && c != "#") begin
                  tmp = acc({1'b0, pa}, c, 13'd4095); pa = tmp[11:0];
                end else begin
                  v = (pa > PulseMax) ? PulseMax : pa;
                  fp = 1'b0;
                  if ({24'd0, ca} < CHANNELS && may_write) begin
                    tab[ca[CW-1:0]] = v;
                    lc = ca[CW-1:0];
                  end
                  ca = '0; pa = '0;
                end
              end
              if (was_time) begin
                tmp = acc({2'd0, ta}, c, 13'd2047); t_new = tmp[10:0]; ta = t_new;
                if (may_write) tab[0] = {1'b0, t_new};
              end
              if (c == 8'h0D && fpt && ta <= TimeLimit) begin
                pd = 1'b1; pc = 3'(lc); pp = tab[lc];
              end
              fpt = was_time;
              if (c == "#") fn = 1'b1;
              if (c == "P") fp = 1'b1;
              if (c == "T") ft = 1'b1;
            end
          end
          if (pos >= PW'(5) && !fa) begin
            if (is_dig(c)) begin
              tmp = acc({1'b0, aa}, c, 13'd4095); aa = tmp[11:0]; ast = 1'b1;
            end else if (!ast && (c == " " || (c >= 8'd9 && c <= 8'd13))) begin
            end else if (!ast && (c == "+" || c == "-")) begin
              ast = 1'b1; an = (c == "-");
            end else fa = 1'b1;
          end
          if (pos >= PW'(3) && !fj) begin
            if (c == ">") begin jr = 1'b1; fj = 1'b1; end
            else if (c == "X") ax = 2'd1;
            else if (c == "Y") ax = 2'd2;
            else if (c == "Z") ax = 2'd0;
            else if (c == "-") ng = ng | ax;
            else if (ax == 2'd1) begin tmp = acc({5'd0, x}, c, 13'd255); x = tmp[7:0]; end
            else if (ax == 2'd2) begin tmp = acc({5'd0, y}, c, 13'd255); y = tmp[7:0]; end
          end
        end
      end
      for (int i = 0; i < CHANNELS; i++) ptab[i] <= tab[i];
      last_ch <= lc;
      if (end_of_message) begin
        msg.code <= code_n; msg.fwd <= fwd_n; msg.range_cm <= range_cm;
        msg.ang_neg <= an; msg.angle <= aa; msg.joy_ready <= jr;
        msg.joy_xneg <= ng[0]; msg.joy_yneg <= ng[1]; msg.joy_x <= x; msg.joy_y <= y;
        msg.pending <= pd; msg.pend_chan <= pc; msg.pend_pulse <= pp;
      end else begin
        for (int i = 0; i < 6; i++) pfx[i] <= pfx_n[i];
        pos <= pos_n;
        {f_num, f_pulse, f_time, f_prevt, f_send, f_tend, f_jend, f_aend} <=
          {fn, fp, ft, fpt, fs, tend, fj, fa};
        chan_acc <= ca; pulse_acc <= pa; time_acc <= ta; ang_acc <= aa;
        ang_started <= ast; ang_neg <= an;
        jx <= x; jy <= y; jaxis <= ax; jneg <= ng; jready <= jr;
        pend <= pd; pend_ch <= pc; pend_pl <= pp;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rccd_queue.sv
// Two-entry queue of message summaries between the parser and the executor.
`default_nettype none
module rccd_queue
  import rccd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  msg_t      push_msg,
  input  wire logic pop,
  output msg_t      head,
  output logic      not_empty,
  output logic      full
);

  msg_t mem [2];
  logic rd, wr;
  logic [1:0] cnt;

  assign not_empty = cnt != 2'd0;
  assign full = cnt == 2'd2;
  assign head = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0; wr <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) begin mem[wr] <= push_msg; wr <= ~wr; end
      if (pop) rd <= ~rd;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rccd_exec.sv
// Back part: carries out a decoded message and holds speed, horn and result.
`default_nettype none
module rccd_exec
  import rccd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [9:0]   speed_reset,
  input  wire logic [9:0]   clear_distance,
  input  wire logic [9:0]   stop_distance,
  input  wire logic [6:0]   dead_zone,
  input  wire logic         in_valid,
  input  msg_t              in_msg,
  output logic              in_take,
  output logic              valid,
  input  wire logic         stall,
  output logic              drive_write,
  output logic signed [10:0] drive_level,
  output logic              servo_write,
  output logic [2:0]        servo_channel,
  output logic [11:0]       servo_pulse,
  output logic              beep_on,
  output logic [9:0]        speed_now,
  output logic              unrecognized
);

  logic [9:0] speed;
  logic       beep;
  logic       rst_seen;

  assign in_take = in_valid && (!valid || !stall);

  always_ff @(posedge clk) begin
    logic dw, sw, un, bp;
    logic signed [10:0] lvl, sp;
    logic [2:0] ch;
    logic [11:0] pl;
    logic [9:0] spd;
    logic signed [9:0] x, y, d;
    dw = 1'b0; sw = 1'b0; un = 1'b0; lvl = '0; ch = '0; pl = '0;
    spd = speed; bp = beep; sp = $signed({1'b0, speed});
    x = in_msg.joy_xneg ? -$signed({2'b0, in_msg.joy_x}) : $signed({2'b0, in_msg.joy_x});
    y = in_msg.joy_yneg ? -$signed({2'b0, in_msg.joy_y}) : $signed({2'b0, in_msg.joy_y});
    d = $signed({3'b0, dead_zone});
    if (in_msg.fwd && in_msg.range_cm > clear_distance) begin
      dw = 1'b1; sw = 1'b1; lvl = sp; ch = 3'd1; pl = PulseCentre;
    end else if (in_msg.code == T_BACK) begin
      dw = 1'b1; sw = 1'b1; lvl = -sp; ch = 3'd1; pl = PulseCentre;
    end else if (in_msg.code == T_LEFT) begin
      dw = 1'b1; sw = 1'b1; lvl = sp; ch = 3'd1; pl = PulseLeft;
    end else if (in_msg.code == T_RIGHT) begin
      dw = 1'b1; sw = 1'b1; lvl = sp; ch = 3'd1; pl = PulseRight;
    end else if (in_msg.code == T_STOP || in_msg.range_cm < stop_distance) begin
      dw = 1'b1; sw = 1'b1; ch = 3'd1; pl = PulseCentre;
    end else if (in_msg.code inside {[T_ANG1:T_ANG6]}) begin
      sw = 1'b1; ch = 3'(in_msg.code - T_ANG1 + 4'd1);
      pl = in_msg.ang_neg ? 12'd0 : in_msg.angle;
    end else if (in_msg.code == T_ADD) begin
      spd = ({1'b0, speed} + 11'd200 >= 11'd990) ? SpeedMax : speed + SpeedStep;
    end else if (in_msg.code == T_SLOW) begin
      spd = (speed < 10'd800) ? SpeedMin : speed - SpeedStep;
    end else if (in_msg.code == T_HORN) begin
      bp = ~beep;
    end else if (in_msg.code == T_NOHORN) begin
      bp = 1'b0;
    end else if (in_msg.code == T_JOY) begin
      if (in_msg.joy_ready) begin
        if (y > -d && y < d && x >= -d && x < d) begin dw = 1'b1; lvl = '0; pl = PulseCentre; end
        if (y >= 0) begin
          if (y >= d && y <= 10'sd99) begin dw = 1'b1; lvl = -sp; pl = PulseCentre; end
        end else if (y > -10'sd99 && y <= -d) begin dw = 1'b1; lvl = sp; pl = PulseCentre; end
        if (x >= 0) begin
          if (x >= d && x < 10'sd99) begin dw = 1'b1; lvl = sp; pl = PulseLeft; end
        end else if (x >= -10'sd99 && x < -d) begin dw = 1'b1; lvl = sp; pl = PulseRight; end
        if (dw) begin sw = 1'b1; ch = 3'd1; end
      end
    end else begin
      if (in_msg.pending) begin sw = 1'b1; ch = in_msg.pend_chan; pl = in_msg.pend_pulse; end
      else un = 1'b1;
    end
    if (!dw) lvl = '0;
    if (!sw) begin ch = '0; pl = '0; end

    if (rst) begin
      valid <= 1'b0; beep <= 1'b0; rst_seen <= 1'b1;
    end else begin
      if (rst_seen) begin speed <= speed_reset; rst_seen <= 1'b0; end
      if (in_take && !rst_seen) begin
        valid <= 1'b1; speed <= spd; beep <= bp;
        drive_write <= dw; drive_level <= lvl; servo_write <= sw;
        servo_channel <= ch; servo_pulse <= pl; beep_on <= bp;
        speed_now <= spd; unrecognized <= un;
      end else if (valid && !stall) begin
        valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/robot_car_command_decoder.sv
// Top level of the robot car command decoder.
`default_nettype none
// Bytes of one command message enter one per cycle on the in channel; the byte
// flagged end_of_message closes the message and produces exactly one result item
// with the drive, servo, horn and speed update. The front parser takes one byte
// per clock and turns each finished message into a summary; a two-entry queue
// passes summaries to the executor, which holds speed and horn state and the
// output register. Sustained rate is one byte per cycle. The parser stalls when
// the queue is full, or when the queue holds one summary that is not being taken
// while another is arriving. The user must write the configuration registers
// (speed_reset, clear_distance, stop_distance, dead_zone) only while the block
// is idle; the block does not enforce it. speed_reset is loaded into the speed
// on the first cycle after reset, and no item is executed before.
module robot_car_command_decoder
  import rccd_pkg::*;
#(
  parameter int MAX_LINE = MaxLineDefault,
  parameter int CHANNELS = ChannelsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [9:0]  range_cm,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             drive_write,
  output logic signed [10:0] drive_level,
  output logic             servo_write,
  output logic [2:0]       servo_channel,
  output logic [11:0]      servo_pulse,
  output logic             beep_on,
  output logic [9:0]       speed_now,
  output logic             unrecognized,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  logic [9:0] speed_reset, clear_distance, stop_distance;
  logic [6:0] dead_zone;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_reset <= 10'd800; clear_distance <= 10'd66;
      stop_distance <= 10'd27; dead_zone <= 7'd30;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgSpeedReset: speed_reset <= cfg_data;
        CfgClearDist:  clear_distance <= cfg_data;
        CfgStopDist:   stop_distance <= cfg_data;
        CfgDeadZone:   dead_zone <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  msg_t pmsg, qhead;
  logic pvalid, qne, qfull, qpop, take;

  // The queue may hold one entry being pushed while full-check guards input.
  assign in_stall = qfull || (pvalid && qne && !qpop);
  assign take = in_valid && !in_stall;

  rccd_parse #(.MAX_LINE(MAX_LINE), .CHANNELS(CHANNELS)) u_parse (
    .clk, .rst, .take, .rx_byte, .range_cm, .end_of_message,
    .msg(pmsg), .msg_valid(pvalid)
  );

  rccd_queue u_queue (
    .clk, .rst, .push(pvalid), .push_msg(pmsg), .pop(qpop),
    .head(qhead), .not_empty(qne), .full(qfull)
  );

  rccd_exec u_exec (
    .clk, .rst, .speed_reset, .clear_distance, .stop_distance, .dead_zone,
    .in_valid(qne), .in_msg(qhead), .in_take(qpop),
    .valid(out_valid), .stall(out_stall),
    .drive_write, .drive_level, .servo_write, .servo_channel, .servo_pulse,
    .beep_on, .speed_now, .unrecognized
  );

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the robot car command decoder.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import rccd_pkg::*;

  localparam int NumChan = 8;
  localparam int LineMax = 512;
  localparam int WatchLimit = 20000;
  localparam int LongHold = 300;

  // One byte of a command message as it is offered on the input channel.
  typedef struct {
    logic [7:0] ch;
    logic [9:0] range_v;
    logic       last;
  } rx_item_t;

  // One decoded command update as the block should present it.
  typedef struct {
    logic               dw;
    logic signed [10:0] lvl;
    logic               sw;
    logic [2:0]         chan;
    logic [11:0]        pulse;
    logic               beep;
    logic [9:0]         spd;
    logic               unrec;
  } update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = '0;
  logic [9:0] range_cm = '0;
  logic end_of_message = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic drive_write, servo_write, beep_on, unrecognized;
  logic signed [10:0] drive_level;
  logic [2:0] servo_channel;
  logic [11:0] servo_pulse;
  logic [9:0] speed_now;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  always #10 clk = ~clk;

  robot_car_command_decoder uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .rx_byte(rx_byte), .range_cm(range_cm), .end_of_message(end_of_message),
    .out_valid(out_valid), .out_stall(out_stall),
    .drive_write(drive_write), .drive_level(drive_level),
    .servo_write(servo_write), .servo_channel(servo_channel),
    .servo_pulse(servo_pulse), .beep_on(beep_on), .speed_now(speed_now),
    .unrecognized(unrecognized),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Bytes waiting to be offered, and updates waiting to be seen at the output.
  rx_item_t rx_pending[$];
  update_t  update_due[$];

  int mismatches = 0;
  int updates_seen = 0;
  int bytes_sent = 0;
  int messages_built = 0;
  bit in_jitter = 1'b1;
  bit out_jitter = 1'b1;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Decoder state kept by the testbench. The settings mirror the block's
  // configuration registers; the rest is the per-message parsing state plus
  // the servo table, speed and horn, which persist across messages.
  // ---------------------------------------------------------------------------
  logic [9:0] set_speed_reset = 10'd800;
  logic [9:0] set_clear = 10'd66;
  logic [9:0] set_stop = 10'd27;
  logic [6:0] set_dead = 7'd30;

  logic [7:0]  lead[6];
  int          pos;
  bit          m_num, m_pulse, m_time, m_prevt, m_send, m_tend, m_jend, m_aend;
  int          chan_acc, pulse_acc, time_acc, ang_acc;
  logic [11:0] pulse_tab[NumChan];
  logic [2:0]  last_chan;
  int          joy_xm, joy_ym;
  int          joy_axis;
  logic [1:0]  joy_neg;
  bit          ang_started, ang_neg, joy_ready;
  int          speed_lvl;
  bit          horn;
  bit          commit_due;
  logic [2:0]  commit_chan;
  logic [11:0] commit_pulse;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int add_digit(int v, logic [7:0] c, int lim);
    if (!is_digit(c)) return v;
    v = v * 10 + int'(c - "0");
    return (v > lim) ? lim : v;
  endfunction

  // True when the message so far is at least as long as the token and starts with it.
  function automatic bit starts_with(string t);
    if (pos < t.len()) return 1'b0;
    for (int i = 0; i < t.len(); i++)
      if (lead[i] != t[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic token_t leading_token();
    if (starts_with("<BDND>") || starts_with("BDND")) return T_BACK;
    if (starts_with("<BLTD>") || starts_with("BLTD")) return T_LEFT;
    if (starts_with("<BRTD>") || starts_with("BRTD")) return T_RIGHT;
    if (starts_with("<BLTU>") || starts_with("<BDNU>") || starts_with("<BUPU>") ||
        starts_with("<BRTU>") || starts_with("BSTD") || starts_with("BLTU") ||
        starts_with("BDNU") || starts_with("BUPU") || starts_with("BRTU")) return T_STOP;
    if (starts_with("<SUP-")) return T_ANG1;
    if (starts_with("<SLT-")) return T_ANG2;
    if (starts_with("<SDN-")) return T_ANG3;
    if (starts_with("<SRT-")) return T_ANG4;
    if (starts_with("<SDL-")) return T_ANG5;
    if (starts_with("<SDR-")) return T_ANG6;
    if (starts_with("BUAD")) return T_ADD;
    if (starts_with("BUMD")) return T_SLOW;
    if (starts_with("BUSD")) return T_HORN;
    if (starts_with("BUSN")) return T_NOHORN;
    if (starts_with("<ZL")) return T_JOY;
    return T_NONE;
  endfunction

  function automatic void clear_line();
    foreach (lead[i]) lead[i] = '0;
    pos = 0;
    {m_num, m_pulse, m_time, m_prevt, m_send, m_tend, m_jend, m_aend} = '0;
    chan_acc = 0; pulse_acc = 0; time_acc = 0; ang_acc = 0;
    joy_xm = 0; joy_ym = 0; joy_axis = 0; joy_neg = '0; joy_ready = 0;
    ang_started = 0; ang_neg = 0;
    commit_due = 0; commit_chan = '0; commit_pulse = '0;
  endfunction

  // The "#chan P pulse T time" servo protocol. Table writes land at once,
  // but only while the message start matches no other token.
  function automatic void servo_proto(logic [7:0] c);
    bit was_time, may_write;
    int v;
    was_time = m_time;
    may_write = (leading_token() == T_NONE);
    if (m_num) begin
      if (c != "P") chan_acc = add_digit(chan_acc, c, 255);
      else m_num = 0;
    end
    if (m_pulse) begin
      if (c != "T" && c != "#") begin
        pulse_acc = add_digit(pulse_acc, c, 4095);
      end else begin
        v = (pulse_acc > 2500) ? 2500 : pulse_acc;
        m_pulse = 0;
        if (chan_acc < NumChan && may_write) begin
          pulse_tab[chan_acc] = v[11:0];
          last_chan = chan_acc[2:0];
        end
        chan_acc = 0; pulse_acc = 0;
      end
    end
    if (was_time) begin
      time_acc = add_digit(time_acc, c, 2047);
      if (may_write) pulse_tab[0] = time_acc[11:0];
    end
    // A carriage return straight after a time byte, with a short time, arms the update.
    if (c == 8'h0d && m_prevt && time_acc <= 100) begin
      commit_due = 1;
      commit_chan = last_chan;
      commit_pulse = pulse_tab[last_chan];
    end
    m_prevt = was_time;
    if (c == "#") m_num = 1;
    if (c == "P") m_pulse = 1;
    if (c == "T") m_time = 1;
  endfunction

  function automatic void angle_char(logic [7:0] c);
    if (is_digit(c)) begin
      ang_acc = add_digit(ang_acc, c, 4095);
      ang_started = 1;
    end else if (!ang_started && (c == " " || (c >= 8'd9 && c <= 8'd13))) begin
    end else if (!ang_started && (c == "+" || c == "-")) begin
      ang_started = 1;
      ang_neg = (c == "-");
    end else begin
      m_aend = 1;
    end
  endfunction

  function automatic void joy_char(logic [7:0] c);
    if (c == ">") begin
      joy_ready = 1; m_jend = 1;
    end else if (c == "X") joy_axis = 1;
    else if (c == "Y") joy_axis = 2;
    else if (c == "Z") joy_axis = 0;
    else if (c == "-") joy_neg = joy_neg | joy_axis[1:0];
    else if (joy_axis == 1) joy_xm = add_digit(joy_xm, c, 255);
    else if (joy_axis == 2) joy_ym = add_digit(joy_ym, c, 255);
  endfunction

  // Works out the command update that a message closing with this byte causes.
  function automatic update_t decode_line(logic [9:0] rng);
    update_t u;
    token_t code;
    int x, y, d;
    u = '{default: '0};
    code = leading_token();
    if ((starts_with("<BUPD>") || starts_with("BUPD")) && rng > set_clear) begin
      u.dw = 1; u.lvl = speed_lvl; u.sw = 1; u.chan = 1; u.pulse = PulseCentre;
    end else if (code == T_BACK) begin
      u.dw = 1; u.lvl = -speed_lvl; u.sw = 1; u.chan = 1; u.pulse = PulseCentre;
    end else if (code == T_LEFT) begin
      u.dw = 1; u.lvl = speed_lvl; u.sw = 1; u.chan = 1; u.pulse = PulseLeft;
    end else if (code == T_RIGHT) begin
      u.dw = 1; u.lvl = speed_lvl; u.sw = 1; u.chan = 1; u.pulse = PulseRight;
    end else if (code == T_STOP || rng < set_stop) begin
      u.dw = 1; u.lvl = 0; u.sw = 1; u.chan = 1; u.pulse = PulseCentre;
    end else if (code >= T_ANG1 && code <= T_ANG6) begin
      u.sw = 1; u.chan = 3'(int'(code) - int'(T_ANG1) + 1);
      u.pulse = ang_neg ? 12'd0 : ang_acc[11:0];
    end else if (code == T_ADD) begin
      speed_lvl = (speed_lvl + 200 >= 990) ? 990 : speed_lvl + 200;
    end else if (code == T_SLOW) begin
      speed_lvl = (speed_lvl < 800) ? 600 : speed_lvl - 200;
    end else if (code == T_HORN) begin
      horn = ~horn;
    end else if (code == T_NOHORN) begin
      horn = 0;
    end else if (code == T_JOY) begin
      if (joy_ready) begin
        x = joy_neg[0] ? -joy_xm : joy_xm;
        y = joy_neg[1] ? -joy_ym : joy_ym;
        d = int'(set_dead);
        // Later rules override earlier ones; an axis in no band adds nothing.
        if (y > -d && y < d && x >= -d && x < d) begin
          u.dw = 1; u.lvl = 0; u.pulse = PulseCentre;
        end
        if (y >= 0) begin
          if (y >= d && y <= 99) begin
            u.dw = 1; u.lvl = -speed_lvl; u.pulse = PulseCentre;
          end
        end else if (y > -99 && y <= -d) begin
          u.dw = 1; u.lvl = speed_lvl; u.pulse = PulseCentre;
        end
        if (x >= 0) begin
          if (x >= d && x < 99) begin
            u.dw = 1; u.lvl = speed_lvl; u.pulse = PulseLeft;
          end
        end else if (x >= -99 && x < -d) begin
          u.dw = 1; u.lvl = speed_lvl; u.pulse = PulseRight;
        end
        if (u.dw) begin
          u.sw = 1; u.chan = 1;
        end else begin
          u.pulse = '0;
        end
      end
    end else begin
      if (commit_due) begin
        u.sw = 1; u.chan = commit_chan; u.pulse = commit_pulse;
      end else begin
        u.unrec = 1;
      end
    end
    u.beep = horn;
    u.spd = speed_lvl[9:0];
    return u;
  endfunction

  // Feeds one accepted byte through the decoder state.
  function automatic void take_byte(logic [7:0] c, logic [9:0] rng, logic last);
    int p;
    if (pos < LineMax) begin
      p = pos;
      pos++;
      if (p < 6) lead[p] = c;
      if (c == 8'd0) m_tend = 1;
      if (!m_tend) begin
        if (!m_send) begin
          if (c == 8'h0a) m_send = 1;
          else servo_proto(c);
        end
        if (p >= 5 && !m_aend) angle_char(c);
        if (p >= 3 && !m_jend) joy_char(c);
      end
    end
    if (last) begin
      update_due.push_back(decode_line(rng));
      clear_line();
    end
  endfunction

  initial begin
    foreach (pulse_tab[i]) pulse_tab[i] = PulseCentre;
    last_chan = '0;
    speed_lvl = 800;
    horn = 0;
    clear_line();
  end

  // ---------------------------------------------------------------------------
  // Input driver: offers queued bytes, holds a stalled item steady, and idles
  // at random when jitter is enabled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        take_byte(rx_byte, range_cm, end_of_message);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (rx_pending.size() > 0 && !(in_jitter && $urandom_range(99) < 23)) begin
          rx_byte <= rx_pending[0].ch;
          range_cm <= rx_pending[0].range_v;
          end_of_message <= rx_pending[0].last;
          void'(rx_pending.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure: random stalls plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_cnt <= LongHold;
      hold_req <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
    out_stall <= (hold_cnt > 1) || hold_req || (out_jitter && $urandom_range(99) < 23);
  end

  // Output monitor: every accepted update is compared with the oldest expected one.
  always @(posedge clk) begin
    update_t want;
    if (!rst && out_valid && !out_stall) begin
      updates_seen++;
      if (update_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected update at %0t", $realtime);
      end else begin
        want = update_due.pop_front();
        if (drive_write !== want.dw || drive_level !== want.lvl ||
            servo_write !== want.sw || servo_channel !== want.chan ||
            servo_pulse !== want.pulse || beep_on !== want.beep ||
            speed_now !== want.spd || unrecognized !== want.unrec) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR at %0t: expected dw=%0b lvl=%0d sw=%0b ch=%0d pulse=%0d",
                     $realtime, want.dw, want.lvl, want.sw, want.chan, want.pulse);
            $display("  beep=%0b spd=%0d unrec=%0b; got dw=%0b lvl=%0d sw=%0b ch=%0d",
                     want.beep, want.spd, want.unrec, drive_write, drive_level,
                     servo_write, servo_channel);
            $display("  pulse=%0d beep=%0b spd=%0d unrec=%0b", servo_pulse, beep_on,
                     speed_now, unrecognized);
          end
        end
      end
    end
  end

  // Watchdog: too long without any item moving on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("Watchdog expired with %0d updates outstanding", update_due.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Message construction helpers.
  // ---------------------------------------------------------------------------
  logic [7:0] line_buf[$];

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  // Random decimal text; now and then very long, to reach the saturation limits.
  function automatic string rand_num(int hi);
    if ($urandom_range(15) == 0) return "99999999";
    if ($urandom_range(15) == 0) return "";
    return $sformatf("%0d", $urandom_range(hi));
  endfunction

  // Distances are biased towards the configured thresholds.
  function automatic logic [9:0] rand_dist();
    case ($urandom_range(4))
      0: return set_clear + 10'($urandom_range(2)) - 10'd1;
      1: return set_stop + 10'($urandom_range(2)) - 10'd1;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  // Queues the built message; the closing byte carries end_of_message.
  function automatic void send_line();
    rx_item_t it;
    if (line_buf.size() == 0) line_buf.push_back(8'h0a);
    foreach (line_buf[i]) begin
      it.ch = line_buf[i];
      it.range_v = rand_dist();
      it.last = (i == line_buf.size() - 1);
      rx_pending.push_back(it);
    end
    line_buf.delete();
    messages_built++;
  endfunction

  function automatic void build_servo();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      put_text({"#", rand_num(9), "P", rand_num(3000)});
      if ($urandom_range(3) != 0) put_text({"T", rand_num(150)});
      if ($urandom_range(4) != 0) line_buf.push_back(8'h0d);
    end
    if ($urandom_range(3) != 0) line_buf.push_back(8'h0a);
    if ($urandom_range(5) == 0) put_text("#3P1200T5\r");
  endfunction

  function automatic void build_joy();
    string ax;
    put_text("<ZL");
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(3))
        0: ax = "X";
        1: ax = "Y";
        2: ax = "Z";
        default: ax = "X";
      endcase
      put_text(ax);
      if ($urandom_range(1)) put_text("-");
      put_text(($urandom_range(7) == 0) ? rand_num(300) : $sformatf("%0d",
               $urandom_range(110)));
    end
    if ($urandom_range(5) != 0) put_text(">");
    if ($urandom_range(3) == 0) put_text("X12>");
  endfunction

  function automatic void build_angle();
    string heads[6] = '{"<SUP-", "<SLT-", "<SDN-", "<SRT-", "<SDL-", "<SDR-"};
    put_text(heads[$urandom_range(5)]);
    repeat ($urandom_range(2)) line_buf.push_back(($urandom_range(1)) ? " " : 8'h09);
    case ($urandom_range(3))
      0: put_text("-");
      1: put_text("+");
      default: ;
    endcase
    put_text(rand_num(4000));
    if ($urandom_range(1)) put_text(">7");
  endfunction

  function automatic void build_token();
    string toks[29] = '{"<BUPD>", "BUPD", "<BDND>", "BDND", "<BLTD>", "BLTD",
      "<BRTD>", "BRTD", "<BLTU>", "<BDNU>", "<BUPU>", "<BRTU>", "BSTD", "BLTU",
      "BDNU", "BUPU", "BRTU", "BUAD", "BUMD", "BUSD", "BUSN", "BUAD", "BUMD",
      "BUSD", "BUPD", "BUPD", "BUA", "<BUPD", "BSTD"};
    put_text(toks[$urandom_range(28)]);
    // A trailing servo fragment must not touch the table behind a token.
    if ($urandom_range(3) == 0) put_text("#2P900T3\r");
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void build_random();
    case ($urandom_range(19))
      0, 1, 2, 3, 4: build_servo();
      5, 6, 7: build_joy();
      8, 9, 10: build_angle();
      11, 12, 13, 14, 15: build_token();
      16, 17: build_noise();
      18: begin
        build_servo();
        line_buf.push_back(8'd0);
        put_text("#1P700T1\r");
      end
      default: build_servo();
    endcase
    send_line();
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [9:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CfgSpeedReset: set_speed_reset = val;
      CfgClearDist: set_clear = val;
      CfgStopDist: set_stop = val;
      CfgDeadZone: set_dead = val[6:0];
      default: ;
    endcase
  endtask

  // Waits until every queued byte is in and every update is out, plus a margin
  // for messages that are still being parsed.
  task automatic drain();
    wait (rx_pending.size() == 0 && !in_valid && update_due.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_phase(int byte_budget);
    int start;
    start = bytes_sent + rx_pending.size();
    while (bytes_sent + rx_pending.size() - start < byte_budget) begin
      build_random();
      wait (rx_pending.size() < 64);
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence: a directed pass with the reset settings, then random phases
  // under a range of settings, the extremes included.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // Directed messages: every token family, the servo protocol edge cases,
    // an empty angle, a negative angle and joystick axes either side of centre.
    in_jitter = 1'b0;
    put_text("<BUPD>"); send_line();
    put_text("BDND"); send_line();
    put_text("<BLTD>"); send_line();
    put_text("BRTD"); send_line();
    put_text("BSTD"); send_line();
    put_text("BUP"); send_line();
    put_text("BUAD"); send_line();
    put_text("BUAD"); send_line();
    put_text("BUMD"); send_line();
    put_text("BUSD"); send_line();
    put_text("BUSN"); send_line();
    put_text("<SUP- 2400"); send_line();
    put_text("<SDR--55"); send_line();
    put_text("<SLT-"); send_line();
    put_text("#5P99999T50\r\n"); send_line();
    put_text("#12P1000T7\r"); send_line();
    put_text("#2P800T200\r"); send_line();
    put_text("<ZLX-40Y-99>"); send_line();
    put_text("<ZLX10Y10>"); send_line();
    put_text("<ZLY-12Z5"); send_line();
    line_buf.push_back(8'hff); line_buf.push_back(8'd0); send_line();
    // A line over the length limit, the bytes past the limit being ignored.
    put_text("#4P1800T2\r");
    repeat (LineMax + 24) line_buf.push_back(8'($urandom_range(255)));
    send_line();
    drain();

    // Default settings, full random jitter, one long receiver hold-off.
    in_jitter = 1'b1;
    hold_req = 1'b1;
    random_phase(120);

    // Lower extremes of every register.
    cfg_write(CfgSpeedReset, 10'd600);
    cfg_write(CfgClearDist, 10'd0);
    cfg_write(CfgStopDist, 10'd0);
    cfg_write(CfgDeadZone, 10'd0);
    in_jitter = 1'b0;
    out_jitter = 1'b0;
    random_phase(110);

    // Upper extremes.
    cfg_write(CfgSpeedReset, 10'd990);
    cfg_write(CfgClearDist, 10'd1023);
    cfg_write(CfgStopDist, 10'd1023);
    cfg_write(CfgDeadZone, 10'd99);
    in_jitter = 1'b1;
    out_jitter = 1'b1;
    random_phase(100);

    // Mid-range random settings with a second long hold-off.
    cfg_write(CfgSpeedReset, 10'($urandom_range(600, 990)));
    cfg_write(CfgClearDist, 10'($urandom_range(1023)));
    cfg_write(CfgStopDist, 10'($urandom_range(100)));
    cfg_write(CfgDeadZone, 10'($urandom_range(99)));
    hold_req = 1'b1;
    random_phase(130);

    cfg_write(CfgClearDist, 10'd66);
    cfg_write(CfgStopDist, 10'd27);
    cfg_write(CfgDeadZone, 10'd30);
    random_phase(130);

    repeat (20) @(posedge clk);
    $display("Covered %0d messages in %0d bytes, %0d updates checked under five settings.",
             messages_built, bytes_sent, updates_seen);
    if (mismatches == 0 && update_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d updates never arrived", mismatches, update_due.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/rccd_pkg.sv
rtl/rccd_parse.sv
rtl/rccd_queue.sv
rtl/rccd_exec.sv
rtl/robot_car_command_decoder.sv
verif/tb_top.sv
